### rtl/json_string_unescaper_defines.svh
// assertion macros used by the port-level checker file
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

// same-cycle implication on clock, disabled in reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on clock, disabled in reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/jsu_pkg.sv
// shared types and constants of the json string unescaper
package jsu_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = $clog2(QueueDepth);

   // bytes produced by one input beat
   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
      logic            last;
   } grp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

### rtl/jsu_front.sv
// front end: parses escapes and builds the byte group of each input beat
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  qstat_type  q_stat,
   output logic       push,
   output grp_type    push_grp
);

   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h6E:   r = 8'h0A;
         8'h72:   r = 8'h0D;
         8'h74:   r = 8'h09;
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0C;
         default: r = c;
      endcase
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_nib(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [7:0]  held_ff [3];
   logic        held_we;
   logic        accept;

   logic [7:0]  dig [4];
   logic [4:0]  nib;
   logic        stop;
   logic [15:0] cp;
   logic [1:0]  code_cnt;
   logic [2:0][7:0] code_b;

   logic [7:0]  rb [3];
   logic [1:0]  rp_cnt;
   logic [1:0]  pos;
   logic [2:0][7:0] rp_b;

   grp_type     grp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = q_stat.full;

   assign dig[0] = held_ff[0];
   assign dig[1] = held_ff[1];
   assign dig[2] = held_ff[2];
   assign dig[3] = req_in_byte;

   // code value from leading hex digits
   always_comb begin
      cp   = '0;
      stop = 1'b0;
      nib  = '0;
      for (int i = 0; i < 4; i++) begin
         nib = hex_nib(dig[i]);
         if (!stop && nib[4]) begin
            cp = {cp[11:0], nib[3:0]};
         end else begin
            stop = 1'b1;
         end
      end
   end

   // utf-8 encoding
   always_comb begin
      code_b = '0;
      if (cp < 16'h0080) begin
         code_cnt  = 2'd1;
         code_b[0] = cp[7:0];
      end else if (cp < 16'h0800) begin
         code_cnt  = 2'd2;
         code_b[0] = 8'hC0 | {3'b000, cp[10:6]};
         code_b[1] = 8'h80 | {2'b00, cp[5:0]};
      end else begin
         code_cnt  = 2'd3;
         code_b[0] = 8'hE0 | {4'h0, cp[15:12]};
         code_b[1] = 8'h80 | {2'b00, cp[11:6]};
         code_b[2] = 8'h80 | {2'b00, cp[5:0]};
      end
   end

   // held chars plus the final byte, reprocessed as plain text
   assign rb[0] = (held_cnt_ff == 2'd0) ? req_in_byte : held_ff[0];
   assign rb[1] = (held_cnt_ff == 2'd1) ? req_in_byte : held_ff[1];
   assign rb[2] = req_in_byte;

   always_comb begin
      rp_cnt = '0;
      rp_b   = '0;
      pos    = '0;
      if (rb[0] != CH_BSLASH || held_cnt_ff == 2'd0) begin
         rp_b[rp_cnt] = rb[0];
         rp_cnt       = rp_cnt + 2'd1;
         pos          = 2'd1;
      end else begin
         if (rb[1] != CH_U) begin
            rp_b[rp_cnt] = escape_map(rb[1]);
            rp_cnt       = rp_cnt + 2'd1;
         end
         pos = 2'd2;
      end
      if (pos == 2'd1 && held_cnt_ff != 2'd0) begin
         if (rb[1] != CH_BSLASH || held_cnt_ff == 2'd1) begin
            rp_b[rp_cnt] = rb[1];
            rp_cnt       = rp_cnt + 2'd1;
            pos          = 2'd2;
         end else begin
            if (rb[2] != CH_U) begin
               rp_b[rp_cnt] = escape_map(rb[2]);
               rp_cnt       = rp_cnt + 2'd1;
            end
            pos = 2'd3;
         end
      end
      if (pos == 2'd2 && held_cnt_ff == 2'd2) begin
         rp_b[rp_cnt] = rb[2];
         rp_cnt       = rp_cnt + 2'd1;
      end
   end

   always_comb begin
      grp.cnt     = '0;
      grp.bytes   = '0;
      grp.last    = req_in_last;
      mode_in     = mode_ff;
      held_cnt_in = held_cnt_ff;
      held_we     = 1'b0;
      case (mode_ff)
         MODE_ESC: begin
            if (req_in_byte == CH_U) begin
               mode_in     = MODE_HEX;
               held_cnt_in = '0;
            end else begin
               grp.cnt      = 2'd1;
               grp.bytes[0] = escape_map(req_in_byte);
               mode_in      = MODE_TEXT;
            end
         end
         MODE_HEX: begin
            if (held_cnt_ff != 2'd3) begin
               if (req_in_last) begin
                  grp.cnt   = rp_cnt;
                  grp.bytes = rp_b;
               end else begin
                  held_we     = 1'b1;
                  held_cnt_in = held_cnt_ff + 2'd1;
               end
            end else begin
               grp.cnt     = code_cnt;
               grp.bytes   = code_b;
               mode_in     = MODE_TEXT;
               held_cnt_in = '0;
            end
         end
         default: begin
            if (req_in_byte == CH_BSLASH && !req_in_last) begin
               mode_in = MODE_ESC;
            end else begin
               grp.cnt      = 2'd1;
               grp.bytes[0] = req_in_byte;
            end
         end
      endcase
      if (req_in_last) begin
         mode_in     = MODE_TEXT;
         held_cnt_in = '0;
      end
   end

   assign push     = accept && (grp.cnt != 2'd0 || req_in_last);
   assign push_grp = grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TEXT;
         held_cnt_ff <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held_we) begin
         held_ff[held_cnt_ff] <= req_in_byte;
      end
   end

endmodule

### rtl/jsu_queue.sv
// short queue of byte groups between front and back
module jsu_queue import jsu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  grp_type   push_grp,
   input  logic      pop,
   output grp_type   head,
   output qstat_type q_stat
);

   grp_type              entry_ff [QueueDepth];
   logic [QueueAw-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueAw:0]     cnt_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (cnt_ff == (QueueAw+1)'(QueueDepth));
   assign q_stat.empty = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_grp;
      end
   end

endmodule

### rtl/jsu_back.sv
// back end: sends the bytes of each queued group one beat at a time
module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  grp_type    head,
   input  qstat_type  q_stat,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       byte_valid_ff, run_last_ff, string_end_ff;
   logic       load, take, at_end;
   logic [1:0] last_idx;

   assign load     = !valid_ff || !rsp_stall;
   assign take     = load && !q_stat.empty;
   assign last_idx = (head.cnt == 2'd0) ? 2'd0 : head.cnt - 2'd1;
   assign at_end   = (idx_ff == last_idx);
   assign pop      = take && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (take) begin
         idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff       <= (head.cnt != 2'd0) ? head.bytes[idx_ff] : 8'h00;
         byte_valid_ff <= (head.cnt != 2'd0);
         run_last_ff   <= at_end;
         string_end_ff <= at_end && head.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = string_end_ff;

endmodule

### rtl/json_string_unescaper.sv
// top level of the streaming json string unescaper
// results pass through the queue entry and then the output register of the back end
// throughput: one input beat per cycle while each yields at most one byte and rsp_stall is low
// a beat yielding n bytes occupies the output for n result beats; the queue absorbs bursts
// reset clears parse mode, held count, queue pointers and output valid
module json_string_unescaper import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);

   qstat_type q_stat;
   logic      push, pop;
   grp_type   push_grp, head;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_stat      (q_stat),
      .push        (push),
      .push_grp    (push_grp)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_stat         (q_stat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

### rtl/jsu_checker.sv
// port-level checks of the json string unescaper and their binding
`include "json_string_unescaper_defines.svh"

module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_string_end
);

   logic [8:0]  req_beat;
   logic [10:0] rsp_beat;
   logic        req_held;
   logic        rsp_held;
   logic        rsp_marker;
   logic        rsp_fin;

   assign req_beat   = {req_in_byte, req_in_last};
   assign rsp_beat   = {rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_string_end};
   assign req_held   = req_valid && req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;
   assign rsp_marker = rsp_valid && !rsp_byte_valid;
   assign rsp_fin    = rsp_valid && rsp_string_end;

   `JSU_ASSERT_NEXT(a_req_hold, req_held, req_valid && $stable(req_beat), "input changed in stall")
   `JSU_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_beat), "result changed in stall")
   `JSU_ASSERT_NOW(a_marker_end, rsp_marker, rsp_run_last && rsp_string_end, "marker not at end")
   `JSU_ASSERT_NOW(a_end_run, rsp_fin, rsp_run_last, "string end without run end")
   `JSU_ASSERT_NOW(a_marker_zero, rsp_marker, rsp_out_byte == 8'h00, "empty marker carries a byte")

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (.*);
